// File: sv/rmpc_pkg.sv
// ---------------------------------------------------------------------------
// rmpc_pkg
// Shared types, codes, constants and helpers of the rudder motor position
// controller.
// ---------------------------------------------------------------------------
package rmpc_pkg;

    localparam int POSITION_BITS = 16;
    localparam int SUM_W         = POSITION_BITS + 12;
    localparam int MAG_W         = POSITION_BITS + 1;
    localparam int GAIN_W        = 8;
    localparam int PROD_W        = MAG_W + GAIN_W;
    localparam int SPEED_W       = PROD_W + 1;
    localparam int PWM_W         = 10;
    localparam int MS_W          = 16;
    localparam int TIME_W        = 32;
    localparam int CMD_W         = 3;
    localparam int DRV_W         = 2;
    localparam int PHASE_W       = 3;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int PIPE_SLOTS    = QUEUE_DEPTH + 3;
    localparam int PIPE_CW       = $clog2(PIPE_SLOTS + 1);

    typedef logic signed [POSITION_BITS-1:0] pos_t;
    typedef logic [TIME_W-1:0]               time_ms_t;
    typedef logic [PWM_W-1:0]                pwm_t;

    localparam logic [CMD_W-1:0] CMD_TICK  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_GOTO  = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_MOVE  = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_STOP  = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_PARK  = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_CALIB = CMD_W'(5);
    localparam logic [CMD_W-1:0] CMD_RECAL = CMD_W'(6);

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STOP_MS     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SPEED       = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPEED       = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN      = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS      = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_PERIOD_MS = CFG_INDEX_W'(5);

    localparam logic [MS_W-1:0]   RST_MIN_STOP_MS     = MS_W'(500);
    localparam logic [PWM_W-1:0]  RST_MIN_SPEED       = PWM_W'(400);
    localparam logic [PWM_W-1:0]  RST_MAX_SPEED       = PWM_W'(800);
    localparam logic [GAIN_W-1:0] RST_SPEED_GAIN      = GAIN_W'(20);
    localparam logic [GAIN_W-1:0] RST_HYSTERESIS      = GAIN_W'(3);
    localparam logic [MS_W-1:0]   RST_CALIB_PERIOD_MS = MS_W'(2000);

    localparam logic [DRV_W-1:0] DRV_OFF  = DRV_W'(0);
    localparam logic [DRV_W-1:0] DRV_BACK = DRV_W'(1);
    localparam logic [DRV_W-1:0] DRV_FWD  = DRV_W'(2);

    localparam logic signed [SUM_W-1:0] NUDGE_COUNTS = SUM_W'(150);
    localparam logic signed [SUM_W-1:0] SPAN_COUNTS  = SUM_W'(1500);
    localparam logic signed [POSITION_BITS:0] ERR_SETTLE = (POSITION_BITS + 1)'(5);
    localparam logic [PWM_W-1:0] PARK_SPEED = PWM_W'(512);

    localparam logic signed [SUM_W-1:0] POS_MAX_S =
        SUM_W'({1'b0, {(POSITION_BITS - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] POS_MIN_S = ~POS_MAX_S;

    typedef enum logic [CMD_W-1:0] {
        OP_TICK, OP_GOTO, OP_MOVE, OP_STOP, OP_PARK, OP_CALIB, OP_RECAL, OP_NONE
    } op_t;

    typedef enum logic [PHASE_W-1:0] {
        CAL_NONE, CAL_NUDGE, CAL_LOW, CAL_HIGH, CAL_CENTER, CAL_ZERO, CAL_DONE
    } cal_phase_t;

    typedef enum logic [1:0] {
        DIR_FWD, DIR_STOP, DIR_BACK
    } dir_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_CAL, BK_ERR, BK_MUL, BK_DRV
    } back_state_t;

    typedef struct packed {
        logic [MS_W-1:0]   min_stop_ms;
        logic [PWM_W-1:0]  min_speed;
        logic [PWM_W-1:0]  max_speed;
        logic [GAIN_W-1:0] speed_gain;
        logic [GAIN_W-1:0] hysteresis;
        logic [MS_W-1:0]   calib_period_ms;
    } cfg_t;

    typedef struct packed {
        op_t      op;
        pos_t     value;
        pos_t     position;
        time_ms_t now;
        logic     start_low;
        logic     stop_low;
        logic     park_low;
    } work_item_t;

    typedef struct packed {
        logic [DRV_W-1:0]   drive_dir;
        pwm_t               pwm;
        pos_t               target_out;
        logic               set_position_valid;
        pos_t               set_position_value;
        logic [PHASE_W-1:0] calib_phase_out;
        logic               blocked;
    } res_t;

    function automatic logic signed [SUM_W-1:0] ext_pos(input pos_t p);
        return SUM_W'(p);
    endfunction

    function automatic pos_t sat_pos(input logic signed [SUM_W-1:0] v);
        if (v > POS_MAX_S)
            return POS_MAX_S[POSITION_BITS-1:0];
        if (v < POS_MIN_S)
            return POS_MIN_S[POSITION_BITS-1:0];
        return v[POSITION_BITS-1:0];
    endfunction

endpackage

// File: sv/rmpc_cmd_if.sv
// ---------------------------------------------------------------------------
// rmpc_cmd_if
// Request channel of the controller: command, position, time, limit inputs.
// ---------------------------------------------------------------------------
interface rmpc_cmd_if;
    import rmpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    pos_t              value;
    pos_t              current_position;
    time_ms_t          time_ms;
    logic              start_pin_low;
    logic              stop_pin_low;
    logic              park_pin_low;

    modport source (
        output valid, command, value, current_position, time_ms,
               start_pin_low, stop_pin_low, park_pin_low,
        input  ready
    );

    modport sink (
        input  valid, command, value, current_position, time_ms,
               start_pin_low, stop_pin_low, park_pin_low,
        output ready
    );
endinterface

// File: sv/rmpc_res_if.sv
// ---------------------------------------------------------------------------
// rmpc_res_if
// Result channel of the controller: drive, PWM, target and status.
// ---------------------------------------------------------------------------
interface rmpc_res_if;
    import rmpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DRV_W-1:0]   drive_dir;
    pwm_t               pwm;
    pos_t               target_out;
    logic               set_position_valid;
    pos_t               set_position_value;
    logic [PHASE_W-1:0] calib_phase_out;
    logic               blocked;

    modport source (
        output valid, drive_dir, pwm, target_out, set_position_valid,
               set_position_value, calib_phase_out, blocked,
        input  ready
    );

    modport sink (
        input  valid, drive_dir, pwm, target_out, set_position_valid,
               set_position_value, calib_phase_out, blocked,
        output ready
    );
endinterface

// File: sv/rudder_motor_position_controller.sv
// ---------------------------------------------------------------------------
// rudder_motor_position_controller
// DC motor position controller with timed calibration, speed law, reversal
// dwell and limit-switch gating.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one request (command, position, time, limit inputs) per
//   valid/ready handshake; result returns exactly one item per request, in
//   order. cfg_we/cfg_index/cfg_data write the six settings while idle.
//   The execution sequencer takes a tick through the calibration step,
//   error, gain multiply and drive decision, and completes every other
//   command in the calibration step; the intake register and a 4-entry
//   queue let requests be taken back to back while the sequencer works.
//   Reset: settings return to defaults, target, calibration and drive state
//   clear, no result is pending.
//   Stall: a result waits in its output register; the sequencer holds at its
//   final step, the queue fills, and cmd.ready drops once intake and queue
//   are full.
// ---------------------------------------------------------------------------
module rudder_motor_position_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    rmpc_cmd_if.sink                         cmd,
    rmpc_res_if.source                       result,
    input  logic                             cfg_we,
    input  logic [rmpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rmpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rmpc_pkg::*;

    cfg_t       cfg;
    logic       push_valid;
    logic       push_ready;
    work_item_t push_item;
    logic       q_valid;
    logic       q_pop;
    work_item_t q_head;

    rmpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rmpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    rmpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    rmpc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .result  (result)
    );
endmodule

// File: sv/rmpc_cfg.sv
// ---------------------------------------------------------------------------
// rmpc_cfg
// Configuration register file with reset defaults.
// ---------------------------------------------------------------------------
module rmpc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rmpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rmpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rmpc_pkg::cfg_t                   cfg
);
    import rmpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_STOP_MS:     cfg_next.min_stop_ms     = cfg_data[MS_W-1:0];
                CFG_MIN_SPEED:       cfg_next.min_speed       = cfg_data[PWM_W-1:0];
                CFG_MAX_SPEED:       cfg_next.max_speed       = cfg_data[PWM_W-1:0];
                CFG_SPEED_GAIN:      cfg_next.speed_gain      = cfg_data[GAIN_W-1:0];
                CFG_HYSTERESIS:      cfg_next.hysteresis      = cfg_data[GAIN_W-1:0];
                CFG_CALIB_PERIOD_MS: cfg_next.calib_period_ms = cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_stop_ms     <= RST_MIN_STOP_MS;
            cfg_reg.min_speed       <= RST_MIN_SPEED;
            cfg_reg.max_speed       <= RST_MAX_SPEED;
            cfg_reg.speed_gain      <= RST_SPEED_GAIN;
            cfg_reg.hysteresis      <= RST_HYSTERESIS;
            cfg_reg.calib_period_ms <= RST_CALIB_PERIOD_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: sv/rmpc_front.sv
// ---------------------------------------------------------------------------
// rmpc_front
// Request intake: accept, decode the command and register the work item.
// ---------------------------------------------------------------------------
module rmpc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    rmpc_cmd_if.sink             cmd,
    output logic                 push_valid,
    input  logic                 push_ready,
    output rmpc_pkg::work_item_t push_item
);
    import rmpc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    work_item_t item_reg;
    work_item_t decoded;
    op_t        op;
    logic       take;

    always_comb
    begin
        unique case (cmd.command)
            CMD_TICK:  op = OP_TICK;
            CMD_GOTO:  op = OP_GOTO;
            CMD_MOVE:  op = OP_MOVE;
            CMD_STOP:  op = OP_STOP;
            CMD_PARK:  op = OP_PARK;
            CMD_CALIB: op = OP_CALIB;
            CMD_RECAL: op = OP_RECAL;
            default:   op = OP_NONE;
        endcase
    end

    always_comb
    begin
        decoded.op        = op;
        decoded.value     = cmd.value;
        decoded.position  = cmd.current_position;
        decoded.now       = cmd.time_ms;
        decoded.start_low = cmd.start_pin_low;
        decoded.stop_low  = cmd.stop_pin_low;
        decoded.park_low  = cmd.park_pin_low;
    end

    assign cmd.ready = !valid_reg || push_ready;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        priority if (take)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= decoded;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;
endmodule

// File: sv/rmpc_queue.sv
// ---------------------------------------------------------------------------
// rmpc_queue
// Short FIFO of decoded work items between intake and execution.
// ---------------------------------------------------------------------------
module rmpc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  rmpc_pkg::work_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop,
    output rmpc_pkg::work_item_t head
);
    import rmpc_pkg::*;

    work_item_t            entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign head       = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QUEUE_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QUEUE_CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_item;
    end
endmodule

// File: sv/rmpc_back.sv
// ---------------------------------------------------------------------------
// rmpc_back
// Execution sequencer: calibration step, error, gain multiply, drive
// decision, and the result register.
// ---------------------------------------------------------------------------
module rmpc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmpc_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  rmpc_pkg::work_item_t q_head,
    rmpc_res_if.source           result
);
    import rmpc_pkg::*;

    back_state_t state_reg, state_next;
    work_item_t  item_reg, item_next;

    pos_t        target_reg, target_next;
    dir_t        last_dir_reg, last_dir_next;
    time_ms_t    stopped_reg, stopped_next;
    logic        held_reg, held_next;
    logic        parking_reg, parking_next;
    cal_phase_t  phase_reg, phase_next;
    time_ms_t    clt_reg, clt_next;
    pos_t        low_end_reg, low_end_next;
    logic [DRV_W-1:0] drive_reg, drive_next;
    pwm_t        pwm_reg, pwm_next;

    pos_t        cur_reg, cur_next;
    logic        setv_reg, setv_next;
    pos_t        setval_reg, setval_next;
    dir_t        dir_reg, dir_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic        out_valid_reg, out_valid_next;
    res_t        res_reg, res_next;

    logic        out_free;
    logic        commit;
    logic        is_tick;
    time_ms_t    clt_min;
    time_ms_t    cal_due_at;
    logic        due;
    logic signed [POSITION_BITS:0] err;
    logic signed [POSITION_BITS:0] diff;
    logic signed [POSITION_BITS:0] diff_adj;
    logic signed [POSITION_BITS:0] half_full;
    pos_t        half;
    logic signed [POSITION_BITS:0] delta;
    dir_t        dir_cand;
    logic [MAG_W-1:0]   mag_abs;
    logic [PWM_W+1:0]   base_tri;
    logic [SPEED_W-1:0] speed;
    pwm_t        spd;
    dir_t        dir_f;
    logic        overwrite;
    logic        reverse;
    time_ms_t    dwell_end;
    logic        dwell;
    logic        blocked;

    assign is_tick = item_reg.op == OP_TICK;
    assign blocked = !item_reg.start_low || !item_reg.stop_low;

    // sequencer outputs
    always_comb
    begin
        out_free = !out_valid_reg || result.ready;
        commit   = ((state_reg == BK_CAL) && !is_tick && out_free) ||
                   ((state_reg == BK_DRV) && out_free);
        q_pop    = q_valid && ((state_reg == BK_IDLE) || commit);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_pop)
                    state_next = BK_CAL;
            end
            BK_CAL:
            begin
                priority if (is_tick)
                    state_next = BK_ERR;
                else if (q_pop)
                    state_next = BK_CAL;
                else if (commit)
                    state_next = BK_IDLE;
                else
                    state_next = state_reg;
            end
            BK_ERR:  state_next = BK_MUL;
            BK_MUL:  state_next = BK_DRV;
            BK_DRV:
            begin
                priority if (q_pop)
                    state_next = BK_CAL;
                else if (commit)
                    state_next = BK_IDLE;
                else
                    state_next = state_reg;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // arithmetic shared by the steps
    always_comb
    begin
        clt_min    = (clt_reg > item_reg.now) ? item_reg.now : clt_reg;
        cal_due_at = clt_min + TIME_W'(cfg.calib_period_ms);
        due        = cal_due_at < item_reg.now;
        err        = (POSITION_BITS + 1)'(target_reg) - (POSITION_BITS + 1)'(item_reg.position);
        diff       = (POSITION_BITS + 1)'(target_reg) - (POSITION_BITS + 1)'(low_end_reg);
        diff_adj   = diff + {{POSITION_BITS{1'b0}}, diff[POSITION_BITS]};
        half_full  = diff_adj >>> 1;
        half       = half_full[POSITION_BITS-1:0];

        delta    = (POSITION_BITS + 1)'(target_reg) - (POSITION_BITS + 1)'(cur_reg);
        dir_cand = delta[POSITION_BITS] ? DIR_FWD : DIR_BACK;
        mag_abs  = delta[POSITION_BITS] ? MAG_W'(-delta) : MAG_W'(delta);

        base_tri = ({2'b00, cfg.min_speed} << 1) + {2'b00, cfg.min_speed};
        speed    = SPEED_W'(prod_reg) + SPEED_W'(base_tri[PWM_W+1:2]);

        if (parking_reg)
        begin
            dir_f     = DIR_FWD;
            spd       = PARK_SPEED;
            overwrite = 1'b1;
        end
        else
        begin
            dir_f     = (speed < SPEED_W'(cfg.min_speed)) ? DIR_STOP : dir_reg;
            spd       = (speed > SPEED_W'(cfg.max_speed)) ? cfg.max_speed
                                                          : speed[PWM_W-1:0];
            overwrite = 1'b0;
        end

        reverse   = ((dir_f == DIR_FWD) && (last_dir_reg == DIR_BACK)) ||
                    ((dir_f == DIR_BACK) && (last_dir_reg == DIR_FWD));
        dwell_end = stopped_reg + TIME_W'(cfg.min_stop_ms);
        dwell     = held_reg && (item_reg.now < dwell_end);
    end

    // step datapath
    always_comb
    begin
        item_next      = item_reg;
        target_next    = target_reg;
        last_dir_next  = last_dir_reg;
        stopped_next   = stopped_reg;
        held_next      = held_reg;
        parking_next   = parking_reg;
        phase_next     = phase_reg;
        clt_next       = clt_reg;
        low_end_next   = low_end_reg;
        drive_next     = drive_reg;
        pwm_next       = pwm_reg;
        cur_next       = cur_reg;
        setv_next      = setv_reg;
        setval_next    = setval_reg;
        dir_next       = dir_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;

        unique case (state_reg)
            BK_CAL:
            begin
                if (is_tick)
                begin
                    clt_next    = due ? item_reg.now : clt_min;
                    cur_next    = item_reg.position;
                    setv_next   = 1'b0;
                    setval_next = '0;
                    if (due)
                    begin
                        unique case (phase_reg)
                            CAL_NUDGE:
                            begin
                                if ((err > -ERR_SETTLE) && (err < ERR_SETTLE))
                                begin
                                    target_next = sat_pos(ext_pos(target_reg) + NUDGE_COUNTS);
                                    phase_next  = CAL_LOW;
                                end
                            end
                            CAL_LOW:
                            begin
                                if (err == '0)
                                begin
                                    target_next = sat_pos(ext_pos(target_reg) - SPAN_COUNTS);
                                    phase_next  = CAL_HIGH;
                                end
                            end
                            CAL_HIGH:
                            begin
                                if (err == '0)
                                begin
                                    low_end_next = target_reg;
                                    target_next  = sat_pos(ext_pos(target_reg) + SPAN_COUNTS);
                                    phase_next   = CAL_CENTER;
                                end
                            end
                            CAL_CENTER:
                            begin
                                if (err == '0)
                                begin
                                    setv_next   = 1'b1;
                                    setval_next = half;
                                    cur_next    = half;
                                    phase_next  = CAL_ZERO;
                                end
                            end
                            CAL_ZERO:
                            begin
                                target_next = '0;
                                phase_next  = CAL_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
                else if (commit)
                begin
                    unique case (item_reg.op)
                        OP_GOTO:
                        begin
                            target_next  = item_reg.value;
                            parking_next = 1'b0;
                        end
                        OP_MOVE:
                        begin
                            target_next  = sat_pos(ext_pos(target_reg) + ext_pos(item_reg.value));
                            parking_next = 1'b0;
                        end
                        OP_STOP:
                        begin
                            parking_next = 1'b0;
                            target_next  = item_reg.position;
                            drive_next   = DRV_OFF;
                            pwm_next     = '0;
                        end
                        OP_PARK:  parking_next = 1'b1;
                        OP_CALIB: phase_next = (phase_reg == CAL_NONE) ? CAL_NUDGE : CAL_ZERO;
                        OP_RECAL: phase_next = CAL_NUDGE;
                        default: ;
                    endcase
                    res_next.drive_dir          = drive_next;
                    res_next.pwm                = pwm_next;
                    res_next.target_out         = target_next;
                    res_next.set_position_valid = 1'b0;
                    res_next.set_position_value = '0;
                    res_next.calib_phase_out    = phase_next;
                    res_next.blocked            = blocked;
                end
            end
            BK_ERR:
            begin
                dir_next = dir_cand;
                mag_next = mag_abs + ((dir_cand == last_dir_reg) ? MAG_W'(cfg.hysteresis)
                                                                 : MAG_W'(0));
            end
            BK_MUL:
            begin
                prod_next = PROD_W'(mag_reg) * PROD_W'(cfg.speed_gain);
            end
            BK_DRV:
            begin
                if (commit)
                begin
                    last_dir_next = dir_f;
                    if (reverse || dwell || (dir_f == DIR_STOP))
                    begin
                        target_next = cur_reg;
                        drive_next  = DRV_OFF;
                        pwm_next    = '0;
                        if (!held_reg)
                        begin
                            stopped_next = item_reg.now;
                            held_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        held_next    = 1'b0;
                        stopped_next = '0;
                        if (dir_f == DIR_BACK)
                        begin
                            if (item_reg.stop_low)
                            begin
                                drive_next = DRV_BACK;
                                pwm_next   = spd;
                            end
                            else
                            begin
                                target_next = cur_reg;
                                drive_next  = DRV_OFF;
                                pwm_next    = '0;
                            end
                        end
                        else if ((item_reg.start_low || overwrite) && item_reg.park_low)
                        begin
                            drive_next = DRV_FWD;
                            pwm_next   = spd;
                        end
                        else
                        begin
                            target_next = cur_reg;
                            drive_next  = DRV_OFF;
                            pwm_next    = '0;
                        end
                    end
                    res_next.drive_dir          = drive_next;
                    res_next.pwm                = pwm_next;
                    res_next.target_out         = target_next;
                    res_next.set_position_valid = setv_reg;
                    res_next.set_position_value = setval_reg;
                    res_next.calib_phase_out    = phase_reg;
                    res_next.blocked            = blocked;
                end
            end
            default: ;
        endcase

        if (q_pop)
            item_next = q_head;
    end

    always_comb
    begin
        priority if (commit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            last_dir_reg  <= DIR_STOP;
            stopped_reg   <= '0;
            held_reg      <= 1'b0;
            parking_reg   <= 1'b0;
            phase_reg     <= CAL_NONE;
            clt_reg       <= '0;
            low_end_reg   <= '0;
            drive_reg     <= DRV_OFF;
            pwm_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            last_dir_reg  <= last_dir_next;
            stopped_reg   <= stopped_next;
            held_reg      <= held_next;
            parking_reg   <= parking_next;
            phase_reg     <= phase_next;
            clt_reg       <= clt_next;
            low_end_reg   <= low_end_next;
            drive_reg     <= drive_next;
            pwm_reg       <= pwm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        cur_reg    <= cur_next;
        setv_reg   <= setv_next;
        setval_reg <= setval_next;
        dir_reg    <= dir_next;
        mag_reg    <= mag_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
    end

    assign result.valid              = out_valid_reg;
    assign result.drive_dir          = res_reg.drive_dir;
    assign result.pwm                = res_reg.pwm;
    assign result.target_out         = res_reg.target_out;
    assign result.set_position_valid = res_reg.set_position_valid;
    assign result.set_position_value = res_reg.set_position_value;
    assign result.calib_phase_out    = res_reg.calib_phase_out;
    assign result.blocked            = res_reg.blocked;
endmodule

// File: sv/rmpc_checker.sv
// ---------------------------------------------------------------------------
// rmpc_checker
// Port-level checks of the controller, bound to the top level.
// ---------------------------------------------------------------------------
module rmpc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [rmpc_pkg::DRV_W-1:0]     drive_dir,
    input rmpc_pkg::pwm_t                 pwm,
    input rmpc_pkg::pos_t                 target_out,
    input logic                           set_position_valid,
    input rmpc_pkg::pos_t                 set_position_value,
    input logic [rmpc_pkg::PHASE_W-1:0]   calib_phase_out,
    input logic                           blocked
);
    import rmpc_pkg::*;

    logic [PIPE_CW-1:0] pending_reg;
    logic               in_acc;
    logic               out_acc;

    assign in_acc  = cmd_valid && cmd_ready;
    assign out_acc = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + PIPE_CW'(in_acc) - PIPE_CW'(out_acc);
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
            $stable({drive_dir, pwm, target_out, set_position_valid,
                     set_position_value, calib_phase_out, blocked}))
        else $error("result changed while stalled");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != '0)
        else $error("result without an outstanding request");

    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == PIPE_CW'(PIPE_SLOTS) |-> !cmd_ready)
        else $error("request taken with every slot occupied");

    a_off_no_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (drive_dir == DRV_OFF) |-> pwm == '0)
        else $error("drive off with nonzero pwm");

    a_reload_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !set_position_valid |-> set_position_value == '0)
        else $error("reload value without reload");
endmodule

bind rudder_motor_position_controller rmpc_checker u_rmpc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .drive_dir          (result.drive_dir),
    .pwm                (result.pwm),
    .target_out         (result.target_out),
    .set_position_valid (result.set_position_valid),
    .set_position_value (result.set_position_value),
    .calib_phase_out    (result.calib_phase_out),
    .blocked            (result.blocked)
);

// File: dv/rmpc_steer_check.sv
// ---------------------------------------------------------------------------
// rmpc_steer_check
// Watches the request, result and settings ports of the rudder motor
// position controller, predicts drive, PWM, target and calibration status
// for every accepted request and compares each result against it in order.
// ---------------------------------------------------------------------------
module rmpc_steer_check (
    input  logic                             clk,
    input  logic                             rst_n,
    rmpc_cmd_if                              cmd,
    rmpc_res_if                              result,
    input  logic                             cfg_we,
    input  logic [rmpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rmpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rmpc_pkg::*;

    cfg_t             cfg;
    pos_t             tgt;
    dir_t             heading;
    time_ms_t         halted_at;
    logic             halt_held;
    logic             parking;
    cal_phase_t       phase;
    time_ms_t         phase_stamp;
    pos_t             low_end;
    logic [DRV_W-1:0] drv;
    pwm_t             duty;
    res_t             expected_drive[$];
    res_t             want;
    int               faults;

    function automatic pos_t clamp_pos(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (POSITION_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return pos_t'(hi);
        if (v < lo)
            return pos_t'(lo);
        return pos_t'(v);
    endfunction

    function automatic void stop_motor(input pos_t at);
        tgt  = at;
        drv  = DRV_OFF;
        duty = '0;
    endfunction

    function automatic void apply_drive(input dir_t dir, input longint speed,
                                        input logic forced, input pos_t at,
                                        input time_ms_t now, input logic sp,
                                        input logic tp, input logic pp);
        logic     reversing;
        logic     dwelling;
        time_ms_t release_at;
        release_at = halted_at + time_ms_t'(cfg.min_stop_ms);
        reversing  = (dir == DIR_FWD && heading == DIR_BACK) ||
                     (dir == DIR_BACK && heading == DIR_FWD);
        dwelling   = halt_held && (now < release_at);
        if (reversing || dwelling || dir == DIR_STOP)
        begin
            stop_motor(at);
            if (!halt_held)
            begin
                halted_at = now;
                halt_held = 1'b1;
            end
        end
        else
        begin
            halt_held = 1'b0;
            halted_at = '0;
            if (dir == DIR_BACK)
            begin
                if (tp)
                begin
                    drv  = DRV_BACK;
                    duty = pwm_t'(speed);
                end
                else
                    stop_motor(at);
            end
            else if ((sp || forced) && pp)
            begin
                drv  = DRV_FWD;
                duty = pwm_t'(speed);
            end
            else
                stop_motor(at);
        end
        heading = dir;
    endfunction

    function automatic res_t predict_drive(input op_t op, input pos_t val,
                                           input pos_t pos, input time_ms_t now,
                                           input logic sp, input logic tp,
                                           input logic pp);
        res_t   r;
        pos_t   at;
        longint err;
        longint speed;
        dir_t   dir;
        logic   reload;
        pos_t   reload_val;
        at         = pos;
        reload     = 1'b0;
        reload_val = '0;
        case (op)
            OP_TICK:
            begin
                if (phase_stamp > now)
                    phase_stamp = now;
                if (time_ms_t'(phase_stamp + time_ms_t'(cfg.calib_period_ms)) < now)
                begin
                    phase_stamp = now;
                    err = longint'(tgt) - longint'(at);
                    case (phase)
                        CAL_NUDGE:
                            if (err > -5 && err < 5)
                            begin
                                tgt   = clamp_pos(longint'(tgt) + 150);
                                phase = CAL_LOW;
                            end
                        CAL_LOW:
                            if (err == 0)
                            begin
                                tgt   = clamp_pos(longint'(tgt) - 1500);
                                phase = CAL_HIGH;
                            end
                        CAL_HIGH:
                            if (err == 0)
                            begin
                                low_end = tgt;
                                tgt     = clamp_pos(longint'(tgt) + 1500);
                                phase   = CAL_CENTER;
                            end
                        CAL_CENTER:
                            if (err == 0)
                            begin
                                reload_val = pos_t'((longint'(tgt) - longint'(low_end)) / 2);
                                reload     = 1'b1;
                                at         = reload_val;
                                phase      = CAL_ZERO;
                            end
                        CAL_ZERO:
                        begin
                            tgt   = '0;
                            phase = CAL_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (parking)
                    apply_drive(DIR_FWD, longint'(PARK_SPEED), 1'b1, at, now, sp, tp, pp);
                else
                begin
                    err = longint'(tgt) - longint'(at);
                    dir = (err < 0) ? DIR_FWD : DIR_BACK;
                    if (err < 0)
                        err = -err;
                    if (dir == heading)
                        err = err + longint'(cfg.hysteresis);
                    speed = err * longint'(cfg.speed_gain) +
                            (longint'(cfg.min_speed) * 3) / 4;
                    if (speed < longint'(cfg.min_speed))
                        dir = DIR_STOP;
                    if (speed > longint'(cfg.max_speed))
                        speed = longint'(cfg.max_speed);
                    apply_drive(dir, speed, 1'b0, at, now, sp, tp, pp);
                end
            end
            OP_GOTO:
            begin
                tgt     = val;
                parking = 1'b0;
            end
            OP_MOVE:
            begin
                parking = 1'b0;
                tgt     = clamp_pos(longint'(tgt) + longint'(val));
            end
            OP_STOP:
            begin
                parking = 1'b0;
                stop_motor(at);
            end
            OP_PARK:
                parking = 1'b1;
            OP_CALIB:
                phase = (phase == CAL_NONE) ? CAL_NUDGE : CAL_ZERO;
            OP_RECAL:
                phase = CAL_NUDGE;
            default:
            begin
            end
        endcase
        r.drive_dir          = drv;
        r.pwm                = duty;
        r.target_out         = tgt;
        r.set_position_valid = reload;
        r.set_position_value = reload_val;
        r.calib_phase_out    = phase;
        r.blocked            = !sp || !tp;
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [31:0] exp_v,
                                        input logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            faults++;
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.min_stop_ms     = RST_MIN_STOP_MS;
            cfg.min_speed       = RST_MIN_SPEED;
            cfg.max_speed       = RST_MAX_SPEED;
            cfg.speed_gain      = RST_SPEED_GAIN;
            cfg.hysteresis      = RST_HYSTERESIS;
            cfg.calib_period_ms = RST_CALIB_PERIOD_MS;
            tgt                 = '0;
            heading             = DIR_STOP;
            halted_at           = '0;
            halt_held           = 1'b0;
            parking             = 1'b0;
            phase               = CAL_NONE;
            phase_stamp         = '0;
            low_end             = '0;
            drv                 = DRV_OFF;
            duty                = '0;
            faults              = 0;
            expected_drive.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_STOP_MS:     cfg.min_stop_ms     = cfg_data[MS_W-1:0];
                    CFG_MIN_SPEED:       cfg.min_speed       = cfg_data[PWM_W-1:0];
                    CFG_MAX_SPEED:       cfg.max_speed       = cfg_data[PWM_W-1:0];
                    CFG_SPEED_GAIN:      cfg.speed_gain      = cfg_data[GAIN_W-1:0];
                    CFG_HYSTERESIS:      cfg.hysteresis      = cfg_data[GAIN_W-1:0];
                    CFG_CALIB_PERIOD_MS: cfg.calib_period_ms = cfg_data[MS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    faults++;
                    $error("result with no request outstanding");
                end
                else
                begin
                    want = expected_drive.pop_front();
                    check_field("drive_dir", want.drive_dir, result.drive_dir);
                    check_field("pwm", want.pwm, result.pwm);
                    check_field("target_out", want.target_out, result.target_out);
                    check_field("set_position_valid", want.set_position_valid,
                                result.set_position_valid);
                    check_field("set_position_value", want.set_position_value,
                                result.set_position_value);
                    check_field("calib_phase_out", want.calib_phase_out,
                                result.calib_phase_out);
                    check_field("blocked", want.blocked, result.blocked);
                end
            end
            if (cmd.valid && cmd.ready)
                expected_drive.push_back(predict_drive(op_t'(cmd.command), cmd.value,
                                                       cmd.current_position, cmd.time_ms,
                                                       cmd.start_pin_low, cmd.stop_pin_low,
                                                       cmd.park_pin_low));
            mismatches <= faults;
            pending    <= expected_drive.size();
        end
    end

endmodule

// File: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives the rudder motor position controller with directed requests at the
// field extremes, then phases of random commands under different settings,
// flow-control patterns and long result stalls; the attached checker
// predicts and compares every result and the verdict comes from its count.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rmpc_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int PHASE_ITEMS = 300;
    localparam int LONG_HOLD   = 150;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     pending;

    int       tx_idle_pct = 38;
    int       rx_idle_pct = 61;
    int       dwell_gap = 500;
    int       calib_gap = 2000;
    int       delivered = 0;
    int       hold_left = 0;
    int       cycles = 0;
    time_ms_t clock_ms;
    pos_t     seen_target = '0;

    rmpc_cmd_if cmd_ch ();
    rmpc_res_if res_ch ();

    rudder_motor_position_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rmpc_steer_check steer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .result     (res_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                delivered++;
                seen_target <= res_ch.target_out;
                if (delivered == 250 || delivered == 1400)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_request(input op_t op, input pos_t val, input pos_t pos,
                                input time_ms_t now, input logic sp, input logic tp,
                                input logic pp);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.command          <= op;
        cmd_ch.value            <= val;
        cmd_ch.current_position <= pos;
        cmd_ch.time_ms          <= now;
        cmd_ch.start_pin_low    <= sp;
        cmd_ch.stop_pin_low     <= tp;
        cmd_ch.park_pin_low     <= pp;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_requests();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
    endtask

    task automatic load_settings(input int ph);
        int v[6];
        case (ph)
            1: v = '{0, 0, 1023, 255, 255, 1};
            2: v = '{65535, 1023, 0, 0, 0, 65535};
            3: v = '{20, 100, 600, 3, 2, 5};
            4: v = '{$urandom_range(65535), $urandom_range(1023), $urandom_range(1023),
                     $urandom_range(255), $urandom_range(255), $urandom_range(1, 65535)};
            default: v = '{$urandom_range(200), $urandom_range(1023), $urandom_range(1023),
                           $urandom_range(255), $urandom_range(255), $urandom_range(1, 64)};
        endcase
        write_reg(CFG_MIN_STOP_MS, v[0]);
        write_reg(CFG_MIN_SPEED, v[1]);
        write_reg(CFG_MAX_SPEED, v[2]);
        write_reg(CFG_SPEED_GAIN, v[3]);
        write_reg(CFG_HYSTERESIS, v[4]);
        write_reg(CFG_CALIB_PERIOD_MS, v[5]);
        cfg_we    <= 1'b0;
        dwell_gap = v[0];
        calib_gap = v[5];
    endtask

    task automatic random_request();
        int   pick;
        int   step;
        op_t  op;
        pos_t val;
        pos_t pos;
        pick = $urandom_range(999);
        if (pick < 600)
            op = OP_TICK;
        else if (pick < 700)
            op = OP_GOTO;
        else if (pick < 790)
            op = OP_MOVE;
        else if (pick < 850)
            op = OP_STOP;
        else if (pick < 895)
            op = OP_PARK;
        else if (pick < 912)
            op = OP_CALIB;
        else if (pick < 930)
            op = OP_RECAL;
        else if (pick < 950)
            op = OP_NONE;
        else
            op = OP_TICK;

        pick = $urandom_range(99);
        if (op == OP_MOVE)
        begin
            if (pick < 70)
                val = pos_t'(int'($urandom_range(600)) - 300);
            else if (pick < 90)
                val = pos_t'($urandom());
            else if (pick < 95)
                val = 16'sh7FFF;
            else
                val = 16'sh8000;
        end
        else if (op == OP_GOTO && pick < 70)
            val = pos_t'(seen_target + int'($urandom_range(400)) - 200);
        else
            val = pos_t'($urandom());

        pick = $urandom_range(99);
        if (pick < 55)
            pos = seen_target;
        else if (pick < 70)
            pos = pos_t'(seen_target + int'($urandom_range(8)) - 4);
        else if (pick < 90)
            pos = pos_t'(seen_target + int'($urandom_range(2000)) - 1000);
        else
            pos = pos_t'($urandom());

        pick = $urandom_range(99);
        step = (calib_gap + dwell_gap) / 4 + 3;
        if (pick < 80)
            clock_ms = clock_ms + $urandom_range(step);
        else if (pick < 86)
            clock_ms = clock_ms - $urandom_range(1, 50);
        else if (pick < 90)
            clock_ms = $urandom();
        else if (pick < 92)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(step);

        send_request(op, val, pos, clock_ms,
                     $urandom_range(99) < 85, $urandom_range(99) < 85,
                     $urandom_range(99) < 85);
    endtask

    initial
    begin
        cmd_ch.valid            <= 1'b0;
        cmd_ch.command          <= OP_TICK;
        cmd_ch.value            <= '0;
        cmd_ch.current_position <= '0;
        cmd_ch.time_ms          <= '0;
        cmd_ch.start_pin_low    <= 1'b1;
        cmd_ch.stop_pin_low     <= 1'b1;
        cmd_ch.park_pin_low     <= 1'b1;
        cfg_we                  <= 1'b0;
        cfg_index               <= CFG_MIN_STOP_MS;
        cfg_data                <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_TICK, 0, 0, 10, 1'b1, 1'b1, 1'b1);
        send_request(OP_GOTO, 16'sh7FFF, 0, 11, 1'b1, 1'b1, 1'b1);
        send_request(OP_TICK, 0, 16'sh8000, 20, 1'b1, 1'b1, 1'b1);
        send_request(OP_GOTO, 16'sh8000, 0, 21, 1'b1, 1'b1, 1'b1);
        send_request(OP_TICK, 0, 16'sh7FFF, 30, 1'b1, 1'b1, 1'b1);
        send_request(OP_MOVE, 16'sh8000, 0, 31, 1'b1, 1'b1, 1'b1);
        send_request(OP_MOVE, 16'sh8000, 0, 32, 1'b1, 1'b1, 1'b1);
        send_request(OP_MOVE, 16'sh7FFF, 0, 33, 1'b1, 1'b1, 1'b1);
        send_request(OP_MOVE, 16'sh7FFF, 0, 34, 1'b1, 1'b1, 1'b1);
        send_request(OP_MOVE, 16'sh7FFF, 0, 35, 1'b1, 1'b1, 1'b1);
        send_request(OP_STOP, 0, 1234, 40, 1'b1, 1'b1, 1'b1);
        send_request(OP_PARK, 0, 1234, 41, 1'b1, 1'b1, 1'b1);
        send_request(OP_TICK, 0, 1234, 2000, 1'b0, 1'b1, 1'b1);
        send_request(OP_TICK, 0, 1234, 2010, 1'b1, 1'b1, 1'b0);
        send_request(OP_NONE, 16'sh5A5A, 16'sh25A5, 2011, 1'b0, 1'b0, 1'b0);
        send_request(OP_CALIB, 0, 1234, 2012, 1'b1, 1'b1, 1'b1);
        send_request(OP_CALIB, 0, 1234, 2013, 1'b1, 1'b1, 1'b1);
        send_request(OP_RECAL, 0, 1234, 2014, 1'b1, 1'b1, 1'b1);
        send_request(OP_GOTO, 100, 1234, 2015, 1'b1, 1'b1, 1'b1);
        send_request(OP_TICK, 0, 100, 1500, 1'b1, 1'b1, 1'b1);
        send_request(OP_TICK, 0, 100, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1);
        send_request(OP_TICK, 0, 96, 32'h0000_0004, 1'b1, 1'b1, 1'b1);
        send_request(OP_TICK, 0, -200, 32'h0000_0010, 1'b1, 1'b1, 1'b1);
        clock_ms = 32'h0000_0020;

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                drain_requests();
                load_settings(ph);
            end
            if (ph < 2)
            begin
                tx_idle_pct = 38;
                rx_idle_pct = 61;
            end
            else if (ph < 4)
            begin
                tx_idle_pct = 61;
                rx_idle_pct = 38;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            repeat (PHASE_ITEMS) random_request();
        end

        drain_requests();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
